// ===== design/double_ended_queue_unit_macros.svh =====
// Assertion macros shared by the double-ended queue design.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH

// The expression must hold at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("%m: invariant violated");

// When the antecedent holds, the consequent must hold in the same cycle.
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// When the antecedent holds, the consequent must hold in the next cycle.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`else

`define DEQ_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define DEQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/deq_pkg.sv =====
package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int MAX_DATA_WIDTH = 64;
    localparam int FIELD_WIDTH    = 32;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } deq_action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    typedef struct packed {
        deq_action_t            action;
        logic [FIELD_WIDTH-1:0] push_value;
    } deq_cmd_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] popped_value;
        deq_status_t            status;
        logic                   now_empty;
    } deq_result_t;

endpackage

// ===== design/double_ended_queue_unit.sv =====
// Bounded double-ended queue of DEPTH entries held in a ring buffer in one
// synchronous memory. A transaction is accepted on a clock edge where start is
// high and busy is low; busy stays low, so a new transaction may be issued in
// every cycle. Each transaction yields exactly one result, presented on the
// result port for one cycle with done high, in the cycle right after the
// transaction was accepted. The popped value comes from the registered
// read port of the element memory. The receiver cannot stall the block, so it
// must take every result in the cycle it appears. A pop on an empty queue
// returns status empty, and a push on a full queue returns status full and
// drops the value; in both cases the queue is left unchanged.
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  deq_pkg::deq_cmd_t    cmd,
    output logic                 done,
    output deq_pkg::deq_result_t result
);

    // Index into the ring, entry count (which must reach DEPTH itself), and a
    // sum wide enough for head plus count before the wrap is taken off.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int MAX_W = deq_pkg::MAX_DATA_WIDTH;

    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // Element storage. The front element lives at head_reg and the rest
    // follow it in ring order. No reset: a pop only ever reads an entry that
    // an earlier push wrote.
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [IDX_W-1:0]      head_reg;
    logic [IDX_W-1:0]      head_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    // Result registers for the transaction accepted in the previous cycle.
    logic                  done_reg;
    logic                  pop_ok_reg;
    logic                  pop_ok_next;
    deq_pkg::deq_status_t  status_reg;
    deq_pkg::deq_status_t  status_next;
    logic                  empty_reg;

    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    logic [SUM_W-1:0]      back_sum;
    logic [SUM_W-1:0]      back_wrap;
    logic [SUM_W-1:0]      last_sum;
    logic [SUM_W-1:0]      last_wrap;
    logic [IDX_W-1:0]      back_idx;
    logic [IDX_W-1:0]      last_idx;
    logic [IDX_W-1:0]      head_dec;
    logic [IDX_W-1:0]      head_inc;

    logic                  mem_wr;
    logic                  mem_rd;
    logic [IDX_W-1:0]      mem_addr;
    logic [MAX_W-1:0]      push_wide;
    logic [MAX_W-1:0]      pop_wide;

    // Every operation touches one entry and finishes its bookkeeping in the
    // accept cycle. A push writes in that cycle and a later pop reads at a
    // later edge, so the same entry is never read and written together.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign is_full  = (count_reg == DEPTH_C);
    assign is_empty = (count_reg == '0);

    // First free slot behind the back element: head + count, wrapped.
    assign back_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign back_wrap = (back_sum >= DEPTH_S) ? (back_sum - DEPTH_S) : back_sum;
    assign back_idx  = back_wrap[IDX_W-1:0];

    // Back element: head + count - 1, wrapped. Only used when not empty.
    assign last_sum  = back_sum - SUM_W'(1);
    assign last_wrap = (last_sum >= DEPTH_S) ? (last_sum - DEPTH_S) : last_sum;
    assign last_idx  = last_wrap[IDX_W-1:0];

    assign head_dec = (head_reg == '0) ? LAST_IDX : (head_reg - IDX_W'(1));
    assign head_inc = (head_reg == LAST_IDX) ? '0 : (head_reg + IDX_W'(1));

    // The push value is widened or cut to the element width; the element is
    // widened or cut back to the result field width on the way out.
    assign push_wide = MAX_W'(cmd.push_value);
    assign pop_wide  = MAX_W'(rd_data_reg);

    always_comb
    begin
        mem_wr      = 1'b0;
        mem_rd      = 1'b0;
        mem_addr    = head_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = deq_pkg::ST_OK;
        pop_ok_next = 1'b0;
        if (accept)
        begin
            case (cmd.action)
                deq_pkg::ACT_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_wr     = 1'b1;
                        mem_addr   = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                deq_pkg::ACT_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_wr     = 1'b1;
                        mem_addr   = back_idx;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                deq_pkg::ACT_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_rd      = 1'b1;
                        pop_ok_next = 1'b1;
                        mem_addr    = head_reg;
                        head_next   = head_inc;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                deq_pkg::ACT_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_rd      = 1'b1;
                        pop_ok_next = 1'b1;
                        mem_addr    = last_idx;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = deq_pkg::ST_OK;
                end
            endcase
        end
    end

    // Element memory: one shared address, write or registered read.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[mem_addr] <= push_wide[DATA_WIDTH-1:0];
        end
        if (mem_rd)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            pop_ok_reg <= 1'b0;
            status_reg <= deq_pkg::ST_OK;
            empty_reg  <= 1'b1;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            done_reg   <= accept;
            pop_ok_reg <= pop_ok_next;
            status_reg <= status_next;
            empty_reg  <= (count_next == '0);
        end
    end

    // A failed pop and every push report zero as the popped value.
    assign done                = done_reg;
    assign result.popped_value = pop_ok_reg ? pop_wide[deq_pkg::FIELD_WIDTH-1:0] : '0;
    assign result.status       = status_reg;
    assign result.now_empty    = empty_reg;

    // The count never runs past the capacity of the ring.
    `DEQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= DEPTH_C)
    // Every accepted transaction produces its result in the next cycle.
    `DEQ_ASSERT_NEXT(a_done_follows, clk, rst_n, accept, done)
    // No result appears without a transaction accepted the cycle before.
    `DEQ_ASSERT_NEXT(a_no_spurious, clk, rst_n, !accept, !done)
    // The empty flag of a result agrees with the count it left behind.
    `DEQ_ASSERT_SAME(a_empty_match, clk, rst_n, done, result.now_empty == (count_reg == '0))
    // A push reported as full really found the ring full.
    `DEQ_ASSERT_SAME(a_full_match, clk, rst_n, done && (result.status == deq_pkg::ST_FULL),
                     count_reg == DEPTH_C)

endmodule
